FILE: rtl/bavg_pkg.sv
// ----------------------------------------------------------------------------
// bavg_pkg
// Shared types and constants of the block average downscaler.
// ----------------------------------------------------------------------------
package bavg_pkg;

  localparam int CH_W       = 8;
  localparam int CFG_DATA_W = 16;
  localparam int IMG_W_W    = 12;
  localparam int IMG_H_W    = 16;
  localparam int BLK_CFG_W  = 5;
  localparam int MODE_W     = 2;
  localparam int COL_OUT_W  = 11;
  localparam int ROW_W      = 16;

  // queue depths
  localparam int MID_DEPTH  = 4;
  localparam int OUT_DEPTH  = 8;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BLOCK_SIZE   = 2'd2,
    CFG_CHANNEL_MODE = 2'd3
  } cfg_idx_e;

  localparam logic [MODE_W-1:0] MODE_BLUE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BGR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALL  = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic first;
    logic emit;
    logic frame_last;
  } flags_t;

  typedef struct packed {
    pixel_t               avg;
    logic [COL_OUT_W-1:0] out_column;
    logic [ROW_W-1:0]     out_row;
    logic                 frame_last;
  } result_t;

endpackage

FILE: rtl/bavg_ram.sv
// ----------------------------------------------------------------------------
// bavg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bavg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bavg_fifo.sv
// ----------------------------------------------------------------------------
// bavg_fifo
// Small register queue, first word in is first word out.
// ----------------------------------------------------------------------------
module bavg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/bavg_front.sv
// ----------------------------------------------------------------------------
// bavg_front
// Raster position tracking: masks the channels, finds the block column,
// marks the first and last pixel of each block and the end of the frame.
// ----------------------------------------------------------------------------
module bavg_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_BLOCK = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            restart_i,
  input  logic                            accept_i,
  input  bavg_pkg::pixel_t                pix_i,
  input  logic [bavg_pkg::MODE_W-1:0]     mode_i,
  input  logic [$clog2(MAX_WIDTH):0]      w_eff_i,
  input  logic [bavg_pkg::IMG_H_W-1:0]    h_eff_i,
  input  logic [$clog2(MAX_BLOCK):0]      s_eff_i,
  output bavg_pkg::pixel_t                pix_o,
  output bavg_pkg::flags_t                flags_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    bcol_o,
  output logic [bavg_pkg::ROW_W-1:0]      brow_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int BW = $clog2(MAX_BLOCK);
  localparam int HW = bavg_pkg::IMG_H_W;

  logic [CW-1:0] pcol_q, pcol_d;
  logic [HW-1:0] prow_q, prow_d;
  logic [BW-1:0] rib_q, rib_d;
  logic [BW-1:0] cib_q, cib_d;
  logic [CW-1:0] bcol_q, bcol_d;
  logic [bavg_pkg::ROW_W-1:0] brow_q, brow_d;

  logic last_col, last_row, rib_end, cib_end;

  assign last_col = ({1'b0, pcol_q} + 1'b1) >= w_eff_i;
  assign last_row = ({1'b0, prow_q} + 1'b1) >= {1'b0, h_eff_i};
  assign rib_end  = ({1'b0, rib_q} + 1'b1) >= s_eff_i;
  assign cib_end  = ({1'b0, cib_q} + 1'b1) >= s_eff_i;

  // mode 3 behaves as all four channels
  always_comb begin
    pix_o       = pix_i;
    pix_o.green = (mode_i != bavg_pkg::MODE_BLUE) ? pix_i.green : '0;
    pix_o.red   = (mode_i != bavg_pkg::MODE_BLUE) ? pix_i.red   : '0;
    pix_o.alpha = (mode_i >= bavg_pkg::MODE_ALL)  ? pix_i.alpha : '0;
  end

  assign flags_o.first      = (rib_q == '0) && (cib_q == '0);
  assign flags_o.emit       = (rib_end || last_row) && (cib_end || last_col);
  assign flags_o.frame_last = last_col && last_row;
  assign bcol_o             = bcol_q;
  assign brow_o             = brow_q;

  always_comb begin
    pcol_d = pcol_q;
    prow_d = prow_q;
    rib_d  = rib_q;
    cib_d  = cib_q;
    bcol_d = bcol_q;
    brow_d = brow_q;
    if (restart_i) begin
      pcol_d = '0;
      prow_d = '0;
      rib_d  = '0;
      cib_d  = '0;
      bcol_d = '0;
      brow_d = '0;
    end else if (accept_i) begin
      if (last_col) begin
        pcol_d = '0;
        cib_d  = '0;
        bcol_d = '0;
        if (last_row) begin
          prow_d = '0;
          rib_d  = '0;
          brow_d = '0;
        end else begin
          prow_d = prow_q + 1'b1;
          if (rib_end) begin
            rib_d  = '0;
            brow_d = brow_q + 1'b1;
          end else begin
            rib_d  = rib_q + 1'b1;
          end
        end
      end else begin
        pcol_d = pcol_q + 1'b1;
        if (cib_end) begin
          cib_d  = '0;
          bcol_d = bcol_q + 1'b1;
        end else begin
          cib_d  = cib_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcol_q <= '0;
      prow_q <= '0;
      rib_q  <= '0;
      cib_q  <= '0;
      bcol_q <= '0;
      brow_q <= '0;
    end else begin
      pcol_q <= pcol_d;
      prow_q <= prow_d;
      rib_q  <= rib_d;
      cib_q  <= cib_d;
      bcol_q <= bcol_d;
      brow_q <= brow_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcol_q <= pcol_q)
    else $error("block column ahead of pixel column");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_col && last_row) |=> (pcol_q == '0 && prow_q == '0 && brow_q == '0))
    else $error("position not back at frame start after last pixel");
`endif

endmodule

FILE: rtl/bavg_back.sv
// ----------------------------------------------------------------------------
// bavg_back
// Block accumulation and averaging: read-modify-write of the per-column
// sums with a one-deep bypass, then a reciprocal multiply for the divide.
// ----------------------------------------------------------------------------
module bavg_back #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_BLOCK = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            mid_empty_i,
  output logic                            mid_pop_o,
  input  bavg_pkg::pixel_t                mid_pix_i,
  input  bavg_pkg::flags_t                mid_flags_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]    mid_bcol_i,
  input  logic [bavg_pkg::ROW_W-1:0]      mid_brow_i,
  input  logic [$clog2(MAX_BLOCK):0]      s_eff_i,
  input  logic                            out_pop_i,
  output logic                            out_push_o,
  output bavg_pkg::result_t               out_data_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int BW    = $clog2(MAX_BLOCK);
  localparam int SW    = BW + 1;
  localparam int SUM_W = $clog2(255 * MAX_BLOCK * MAX_BLOCK + 1);
  // exact floor(n / d) for n < 2**SUM_W, d <= 2**(2*BW)
  localparam int K     = SUM_W + 2 * BW;
  localparam int RW    = K + 1;
  localparam int PW    = SUM_W + RW;
  localparam int CRW   = $clog2(bavg_pkg::OUT_DEPTH + 1);
  localparam int CH_W  = bavg_pkg::CH_W;

  typedef logic [3:0][SUM_W-1:0] sums_t;

  // reciprocal table, ceil(2**K / (s*s))
  logic [RW-1:0] rcp_tab [2**SW];
  for (genvar g = 0; g < 2**SW; g++) begin : g_rcp
    if (g == 0 || g > MAX_BLOCK) begin : g_none
      assign rcp_tab[g] = '0;
    end else begin : g_div
      localparam logic [63:0] DIV = 64'(g * g);
      localparam logic [63:0] RCP = ((64'd1 << K) + DIV - 64'd1) / DIV;
      assign rcp_tab[g] = RCP[RW-1:0];
    end
  end

  logic [CRW-1:0] credit_q, credit_d;

  // accumulate stage
  logic                       v1_q;
  bavg_pkg::pixel_t           pix1_q;
  bavg_pkg::flags_t           fl1_q;
  logic [CW-1:0]              bc1_q;
  logic [bavg_pkg::ROW_W-1:0] brow1_q;

  // last write, for back-to-back hits on one column
  logic                       last_v_q;
  logic [CW-1:0]              last_bc_q;
  sums_t                      last_sum_q;

  // multiply stage
  logic                       v2_q;
  sums_t                      sum2_q;
  logic [CW-1:0]              bc2_q;
  logic [bavg_pkg::ROW_W-1:0] brow2_q;
  logic                       fl2_q;
  logic [RW-1:0]              rcp_q;

  // output stage
  logic                       v3_q;
  logic [3:0][PW-1:0]         prod_q;
  logic [CW-1:0]              bc3_q;
  logic [bavg_pkg::ROW_W-1:0] brow3_q;
  logic                       fl3_q;

  logic [4*SUM_W-1:0]         ram_rdata;
  sums_t                      rd_sum, base_sum, new_sum;
  logic [3:0][CH_W-1:0]       px1;
  logic                       last_hit;
  logic [31:0]                bc_ext;

  assign mid_pop_o = !mid_empty_i && (credit_q != '0);

  bavg_ram #(
    .WIDTH (4 * SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (v1_q),
    .waddr_i (bc1_q),
    .wdata_i (new_sum),
    .raddr_i (mid_bcol_i),
    .rdata_o (ram_rdata)
  );

  assign rd_sum   = ram_rdata;
  assign px1      = pix1_q;
  assign last_hit = last_v_q && (last_bc_q == bc1_q);
  assign base_sum = last_hit ? last_sum_q : rd_sum;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      new_sum[k] = fl1_q.first ? SUM_W'(px1[k]) : base_sum[k] + SUM_W'(px1[k]);
    end
  end

  // output slot held from pop until the result leaves or no block closes
  always_comb begin
    credit_d = credit_q - CRW'(mid_pop_o) + CRW'(v1_q && !fl1_q.emit) + CRW'(out_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= CRW'(bavg_pkg::OUT_DEPTH);
      v1_q     <= 1'b0;
      last_v_q <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
    end else begin
      credit_q <= credit_d;
      v1_q     <= mid_pop_o;
      last_v_q <= v1_q;
      v2_q     <= v1_q && fl1_q.emit;
      v3_q     <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix1_q     <= mid_pix_i;
    fl1_q      <= mid_flags_i;
    bc1_q      <= mid_bcol_i;
    brow1_q    <= mid_brow_i;
    last_bc_q  <= bc1_q;
    last_sum_q <= new_sum;
    sum2_q     <= new_sum;
    bc2_q      <= bc1_q;
    brow2_q    <= brow1_q;
    fl2_q      <= fl1_q.frame_last;
    rcp_q      <= rcp_tab[s_eff_i];
    for (int k = 0; k < 4; k++) begin
      prod_q[k] <= sum2_q[k] * rcp_q;
    end
    bc3_q      <= bc2_q;
    brow3_q    <= brow2_q;
    fl3_q      <= fl2_q;
  end

  assign bc_ext = 32'(bc3_q);

  assign out_push_o                = v3_q;
  assign out_data_o.avg.blue       = prod_q[0][K+CH_W-1:K];
  assign out_data_o.avg.green      = prod_q[1][K+CH_W-1:K];
  assign out_data_o.avg.red        = prod_q[2][K+CH_W-1:K];
  assign out_data_o.avg.alpha      = prod_q[3][K+CH_W-1:K];
  assign out_data_o.out_column     = bc_ext[bavg_pkg::COL_OUT_W-1:0];
  assign out_data_o.out_row        = brow3_q;
  assign out_data_o.frame_last     = fl3_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CRW'(bavg_pkg::OUT_DEPTH))
    else $error("output credit above queue depth");
`endif

endmodule

FILE: rtl/block_average_downscaler_core.sv
// ----------------------------------------------------------------------------
// block_average_downscaler_core
// Box-filter downscaler for a raster stream of four-byte pixels.
// ----------------------------------------------------------------------------
// Pixels go in on a queue-style port in raster order and one averaged word
// comes out for every S by S block, smaller at the right and bottom edges,
// once the block's last pixel is taken in. It sustains one pixel per clock
// while results are popped; a result passes the per-column sum memory read,
// the accumulate with its one-deep bypass, the reciprocal multiply and the
// output queue. Up to four pixels queue between the position tracker and the
// accumulator, and eight results wait in the output queue. Registers must be
// written by the user only while the block is idle, unchecked by the block;
// any write restarts the frame. The sum memory needs no clearing pass: each
// entry is written by the first pixel of its block before it is read.
module block_average_downscaler_core #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_BLOCK = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [bavg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                push,
  output logic                                full,
  input  logic [bavg_pkg::CH_W-1:0]           blue_i,
  input  logic [bavg_pkg::CH_W-1:0]           green_i,
  input  logic [bavg_pkg::CH_W-1:0]           red_i,
  input  logic [bavg_pkg::CH_W-1:0]           alpha_byte_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [bavg_pkg::CH_W-1:0]           avg_blue_o,
  output logic [bavg_pkg::CH_W-1:0]           avg_green_o,
  output logic [bavg_pkg::CH_W-1:0]           avg_red_o,
  output logic [bavg_pkg::CH_W-1:0]           avg_alpha_o,
  output logic [bavg_pkg::COL_OUT_W-1:0]      out_column_o,
  output logic [bavg_pkg::ROW_W-1:0]          out_row_o,
  output logic                                frame_last_o
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CW1  = CW + 1;
  localparam int SW   = $clog2(MAX_BLOCK) + 1;
  localparam int MIDW = $bits(bavg_pkg::pixel_t) + $bits(bavg_pkg::flags_t)
                        + CW + bavg_pkg::ROW_W;
  localparam int OUTW = $bits(bavg_pkg::result_t);

  logic [bavg_pkg::IMG_W_W-1:0]   width_q;
  logic [bavg_pkg::IMG_H_W-1:0]   height_q;
  logic [bavg_pkg::BLK_CFG_W-1:0] bsize_q;
  logic [bavg_pkg::MODE_W-1:0]    mode_q;

  logic [CW:0]                    w_eff;
  logic [bavg_pkg::IMG_H_W-1:0]   h_eff;
  logic [SW-1:0]                  s_eff;

  logic                           in_acc;
  bavg_pkg::pixel_t               in_pix;
  bavg_pkg::pixel_t               f_pix;
  bavg_pkg::flags_t               f_flags;
  logic [CW-1:0]                  f_bcol;
  logic [bavg_pkg::ROW_W-1:0]     f_brow;

  logic [MIDW-1:0]                mid_wdata, mid_rdata;
  logic                           mid_full, mid_empty, mid_pop;
  bavg_pkg::pixel_t               m_pix;
  bavg_pkg::flags_t               m_flags;
  logic [CW-1:0]                  m_bcol;
  logic [bavg_pkg::ROW_W-1:0]     m_brow;

  logic                           out_push, out_full, out_pop;
  bavg_pkg::result_t              out_wres, out_rres;
  logic [OUTW-1:0]                out_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bavg_pkg::IMG_W_W'(1);
      height_q <= bavg_pkg::IMG_H_W'(1);
      bsize_q  <= bavg_pkg::BLK_CFG_W'(1);
      mode_q   <= bavg_pkg::MODE_BGR;
    end else if (cfg_we_i) begin
      unique case (bavg_pkg::cfg_idx_e'(cfg_idx_i))
        bavg_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[bavg_pkg::IMG_W_W-1:0];
        bavg_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[bavg_pkg::IMG_H_W-1:0];
        bavg_pkg::CFG_BLOCK_SIZE:   bsize_q  <= cfg_data_i[bavg_pkg::BLK_CFG_W-1:0];
        bavg_pkg::CFG_CHANNEL_MODE: mode_q   <= cfg_data_i[bavg_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero means one; oversize width and block size clamp to the build limit
  always_comb begin
    if (width_q == '0) begin
      w_eff = CW1'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = CW1'(MAX_WIDTH);
    end else begin
      w_eff = CW1'(width_q);
    end
    if (bsize_q == '0) begin
      s_eff = SW'(1);
    end else if (32'(bsize_q) > 32'(MAX_BLOCK)) begin
      s_eff = SW'(MAX_BLOCK);
    end else begin
      s_eff = SW'(bsize_q);
    end
    h_eff = (height_q == '0) ? bavg_pkg::IMG_H_W'(1) : height_q;
  end

  assign in_acc       = push && !mid_full;
  assign full         = mid_full;
  assign in_pix.blue  = blue_i;
  assign in_pix.green = green_i;
  assign in_pix.red   = red_i;
  assign in_pix.alpha = alpha_byte_i;

  bavg_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .accept_i  (in_acc),
    .pix_i     (in_pix),
    .mode_i    (mode_q),
    .w_eff_i   (w_eff),
    .h_eff_i   (h_eff),
    .s_eff_i   (s_eff),
    .pix_o     (f_pix),
    .flags_o   (f_flags),
    .bcol_o    (f_bcol),
    .brow_o    (f_brow)
  );

  assign mid_wdata = {f_pix, f_flags, f_bcol, f_brow};
  assign {m_pix, m_flags, m_bcol, m_brow} = mid_rdata;

  bavg_fifo #(
    .WIDTH (MIDW),
    .DEPTH (bavg_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .wdata_i (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  bavg_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .mid_pix_i   (m_pix),
    .mid_flags_i (m_flags),
    .mid_bcol_i  (m_bcol),
    .mid_brow_i  (m_brow),
    .s_eff_i     (s_eff),
    .out_pop_i   (out_pop),
    .out_push_o  (out_push),
    .out_data_o  (out_wres)
  );

  assign out_pop = pop && !empty;

  bavg_fifo #(
    .WIDTH (OUTW),
    .DEPTH (bavg_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wres),
    .full_o  (out_full),
    .pop_i   (out_pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign out_rres     = out_rdata;
  assign avg_blue_o   = out_rres.avg.blue;
  assign avg_green_o  = out_rres.avg.green;
  assign avg_red_o    = out_rres.avg.red;
  assign avg_alpha_o  = out_rres.avg.alpha;
  assign out_column_o = out_rres.out_column;
  assign out_row_o    = out_rres.out_row;
  assign frame_last_o = out_rres.frame_last;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_push && out_full))
    else $error("result pushed into a full output queue");
`endif

endmodule

FILE: tb/sv/block_average_downscaler_core_test.sv
// ----------------------------------------------------------------------------
// block_average_downscaler_core_test
// Self-checking test of the block average downscaler core.
// ----------------------------------------------------------------------------
// Pixels are pushed in raster order in random bursts while the result side
// pops on a stall pattern of its own. A behavioural model of the downscaler
// runs beside the core: it tracks the pixel position, keeps one set of channel
// sums per block column and queues the averaged word that each closing pixel
// produces. Every popped word is compared field by field with the oldest
// queued word. Registers are rewritten only once the core has gone quiet.
// ----------------------------------------------------------------------------
module block_average_downscaler_core_test;

  localparam int MAX_W         = 2048;
  localparam int MAX_B         = 16;
  localparam int TAIL_CYCLES   = 24;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_PIXELS = 200;

  typedef enum int {
    POP_ALWAYS,
    POP_MOSTLY,
    POP_RARELY,
    POP_BURSTY
  } pop_style_e;

  logic                            clk_i    = 1'b0;
  logic                            rst_ni   = 1'b0;
  logic                            cfg_we   = 1'b0;
  logic [1:0]                      cfg_idx  = '0;
  logic [bavg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            push     = 1'b0;
  logic                            pop      = 1'b0;
  logic [bavg_pkg::CH_W-1:0]       blue_in  = '0;
  logic [bavg_pkg::CH_W-1:0]       green_in = '0;
  logic [bavg_pkg::CH_W-1:0]       red_in   = '0;
  logic [bavg_pkg::CH_W-1:0]       alpha_in = '0;
  logic                            full;
  logic                            empty;
  logic [bavg_pkg::CH_W-1:0]       avg_blue;
  logic [bavg_pkg::CH_W-1:0]       avg_green;
  logic [bavg_pkg::CH_W-1:0]       avg_red;
  logic [bavg_pkg::CH_W-1:0]       avg_alpha;
  logic [bavg_pkg::COL_OUT_W-1:0]  out_column;
  logic [bavg_pkg::ROW_W-1:0]      out_row;
  logic                            frame_last;

  // model copy of the registers, reset values
  logic [bavg_pkg::IMG_W_W-1:0]    width_reg  = bavg_pkg::IMG_W_W'(1);
  logic [bavg_pkg::IMG_H_W-1:0]    height_reg = bavg_pkg::IMG_H_W'(1);
  logic [bavg_pkg::BLK_CFG_W-1:0]  block_reg  = bavg_pkg::BLK_CFG_W'(1);
  logic [bavg_pkg::MODE_W-1:0]     mode_reg   = bavg_pkg::MODE_BGR;

  // model position and per-column sums
  int unsigned       chan_sum [MAX_W][4];
  int unsigned       pix_col    = 0;
  int unsigned       pix_row    = 0;
  int unsigned       row_in_blk = 0;
  int unsigned       col_in_blk = 0;
  int unsigned       blk_col    = 0;
  bavg_pkg::result_t avg_q [$];

  int errors        = 0;
  int pixels_sent   = 0;
  int words_checked = 0;
  int settings_used = 0;
  int burst_left    = 0;
  int gap_left      = 0;

  pop_style_e pop_style = POP_ALWAYS;
  int         pat_left  = 0;
  int         hold_left = 0;

  block_average_downscaler_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .push         (push),
    .full         (full),
    .blue_i       (blue_in),
    .green_i      (green_in),
    .red_i        (red_in),
    .alpha_byte_i (alpha_in),
    .empty        (empty),
    .pop          (pop),
    .avg_blue_o   (avg_blue),
    .avg_green_o  (avg_green),
    .avg_red_o    (avg_red),
    .avg_alpha_o  (avg_alpha),
    .out_column_o (out_column),
    .out_row_o    (out_row),
    .frame_last_o (frame_last)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_width(input logic [bavg_pkg::IMG_W_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  function automatic int unsigned eff_height(input logic [bavg_pkg::IMG_H_W-1:0] h);
    return (h == 0) ? 1 : h;
  endfunction

  function automatic int unsigned eff_block(input logic [bavg_pkg::BLK_CFG_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_B) return MAX_B;
    return s;
  endfunction

  function automatic void restart_position();
    pix_col    = 0;
    pix_row    = 0;
    row_in_blk = 0;
    col_in_blk = 0;
    blk_col    = 0;
  endfunction

  function automatic void apply_reg(input logic [1:0] idx,
                                    input logic [bavg_pkg::CFG_DATA_W-1:0] data);
    case (bavg_pkg::cfg_idx_e'(idx))
      bavg_pkg::CFG_IMAGE_WIDTH:  width_reg  = data[bavg_pkg::IMG_W_W-1:0];
      bavg_pkg::CFG_IMAGE_HEIGHT: height_reg = data[bavg_pkg::IMG_H_W-1:0];
      bavg_pkg::CFG_BLOCK_SIZE:   block_reg  = data[bavg_pkg::BLK_CFG_W-1:0];
      bavg_pkg::CFG_CHANNEL_MODE: mode_reg   = data[bavg_pkg::MODE_W-1:0];
      default: ;
    endcase
    restart_position();
  endfunction

  // accumulate one pixel and queue the average when it closes a block
  function automatic void predict_pixel(input logic [bavg_pkg::CH_W-1:0] b, g, r, a);
    int unsigned w, h, s, bc, dv, k;
    int unsigned px [4];
    bit last_col, last_row;
    bavg_pkg::result_t word;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    s = eff_block(block_reg);
    px[0] = b;
    px[1] = (mode_reg >= bavg_pkg::MODE_BGR) ? g : 0;
    px[2] = (mode_reg >= bavg_pkg::MODE_BGR) ? r : 0;
    px[3] = (mode_reg >= bavg_pkg::MODE_ALL) ? a : 0;
    bc = blk_col % MAX_W;
    for (k = 0; k < 4; k++) begin
      if (row_in_blk == 0 && col_in_blk == 0) chan_sum[bc][k] = px[k];
      else chan_sum[bc][k] += px[k];
    end
    last_col = (pix_col + 1 >= w);
    last_row = (pix_row + 1 >= h);
    if ((row_in_blk + 1 >= s || last_row) && (col_in_blk + 1 >= s || last_col)) begin
      dv = s * s;
      word.avg.blue   = bavg_pkg::CH_W'(chan_sum[bc][0] / dv);
      word.avg.green  = bavg_pkg::CH_W'(chan_sum[bc][1] / dv);
      word.avg.red    = bavg_pkg::CH_W'(chan_sum[bc][2] / dv);
      word.avg.alpha  = bavg_pkg::CH_W'(chan_sum[bc][3] / dv);
      word.out_column = bavg_pkg::COL_OUT_W'(bc);
      word.out_row    = bavg_pkg::ROW_W'(pix_row / s);
      word.frame_last = last_col && last_row;
      avg_q.push_back(word);
    end
    if (last_col) begin
      pix_col    = 0;
      col_in_blk = 0;
      blk_col    = 0;
      if (last_row) begin
        pix_row    = 0;
        row_in_blk = 0;
      end else begin
        pix_row++;
        row_in_blk = (row_in_blk + 1 >= s) ? 0 : row_in_blk + 1;
      end
    end else begin
      pix_col++;
      if (col_in_blk + 1 >= s) begin
        col_in_blk = 0;
        blk_col++;
      end else begin
        col_in_blk++;
      end
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_word();
    bavg_pkg::result_t want;
    if (avg_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected word, expected none, actual col %0d row %0d blue %0d",
               $time, out_column, out_row, avg_blue);
    end else begin
      want = avg_q.pop_front();
      check_field("avg_blue", want.avg.blue, avg_blue);
      check_field("avg_green", want.avg.green, avg_green);
      check_field("avg_red", want.avg.red, avg_red);
      check_field("avg_alpha", want.avg.alpha, avg_alpha);
      check_field("out_column", want.out_column, out_column);
      check_field("out_row", want.out_row, out_row);
      check_field("frame_last", want.frame_last, frame_last);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) apply_reg(cfg_idx, cfg_data);
      if (push && !full) begin
        predict_pixel(blue_in, green_in, red_in, alpha_in);
        pixels_sent++;
      end
      if (pop && !empty) begin
        check_word();
        words_checked++;
      end
    end
  end

  // result side stalls on a pattern that is picked at random from four styles
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pop_style = pop_style_e'($urandom_range(0, 3));
        pat_left  = $urandom_range(30, 250);
      end
      pat_left--;
      case (pop_style)
        POP_ALWAYS: pop <= 1'b1;
        POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
        POP_RARELY: pop <= ($urandom_range(0, 3) == 0);
        default: begin
          if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
          end else begin
            pop <= 1'b1;
            hold_left = $urandom_range(4, 24);
          end
        end
      endcase
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // called at a falling edge; push is left high so a following word goes back to back
  task automatic send_pixel(input logic [bavg_pkg::CH_W-1:0] b, g, r, a);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
    end
    if (gap_left > 0) begin
      push <= 1'b0;
      repeat (gap_left) @(negedge clk_i);
      gap_left = 0;
    end
    burst_left--;
    push     <= 1'b1;
    blue_in  <= b;
    green_in <= g;
    red_in   <= r;
    alpha_in <= a;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_pixel();
    send_pixel(bavg_pkg::CH_W'($urandom_range(0, 255)), bavg_pkg::CH_W'($urandom_range(0, 255)),
               bavg_pkg::CH_W'($urandom_range(0, 255)), bavg_pkg::CH_W'($urandom_range(0, 255)));
  endtask

  task automatic wait_words_done();
    push <= 1'b0;
    do @(negedge clk_i); while (avg_q.size() != 0);
  endtask

  // pixels that close no block may still be in flight after the last word
  task automatic settle();
    wait_words_done();
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input bavg_pkg::cfg_idx_e idx,
                           input logic [bavg_pkg::CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [bavg_pkg::CFG_DATA_W-1:0] w, h, s, mode);
    settle();
    write_reg(bavg_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(bavg_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(bavg_pkg::CFG_BLOCK_SIZE, s);
    write_reg(bavg_pkg::CFG_CHANNEL_MODE, mode);
    settings_used++;
  endtask

  task automatic test_pass_through();
    int unsigned mode;
    // reset values give a one pixel image with no downscale
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    for (mode = bavg_pkg::MODE_BLUE; mode <= 3; mode++) begin
      configure(2, 1, 1, bavg_pkg::CFG_DATA_W'(mode));
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_random_pixel();
    end
  endtask

  task automatic test_special_cases();
    int n;
    // zero sizes act as one
    configure(0, 0, 1, bavg_pkg::MODE_ALL);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00, 8'hFF);
    configure(2, 1, 0, bavg_pkg::MODE_BGR);
    send_random_pixel();
    send_random_pixel();
    // oversized block on a one pixel image, divisor stays full
    configure(1, 1, 31, bavg_pkg::MODE_ALL);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // a register write mid frame restarts the position
    configure(2, 1, 2, bavg_pkg::MODE_ALL);
    send_random_pixel();
    settle();
    write_reg(bavg_pkg::CFG_CHANNEL_MODE, bavg_pkg::MODE_ALL);
    send_random_pixel();
    send_random_pixel();
    // partial blocks at the right and bottom edges
    configure(3, 3, 2, bavg_pkg::MODE_ALL);
    for (n = 0; n < 9; n++) begin
      if (n % 2 == 0) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      else send_random_pixel();
    end
  endtask

  task automatic test_random_frames();
    int unsigned w, h, s, mode, count, n, sel, sent;
    int pause_at;
    bit first;
    sent  = 0;
    first = 1;
    while (sent < RANDOM_PIXELS) begin
      sel = $urandom_range(0, 9);
      w = (sel < 7) ? $urandom_range(1, 12) : (sel == 7) ? 0 : $urandom_range(13, 48);
      sel = $urandom_range(0, 9);
      h = (sel < 7) ? $urandom_range(1, 8) : (sel == 7) ? 0 : $urandom_range(9, 20);
      sel = $urandom_range(0, 9);
      s = (sel < 6) ? $urandom_range(1, 4) : (sel == 6) ? 0 :
          (sel < 9) ? $urandom_range(5, 16) : $urandom_range(17, 31);
      mode = $urandom_range(0, 3);
      // junk above the width, block size and mode fields is dropped by the core
      configure(bavg_pkg::CFG_DATA_W'(($urandom & 16'hF000) | w),
                bavg_pkg::CFG_DATA_W'(h),
                bavg_pkg::CFG_DATA_W'(($urandom & 16'hFFE0) | s),
                bavg_pkg::CFG_DATA_W'(($urandom & 16'hFFFC) | mode));
      count = eff_width(bavg_pkg::IMG_W_W'(w)) * eff_height(bavg_pkg::IMG_H_W'(h)) *
              $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      if (count > RANDOM_PIXELS - sent) count = RANDOM_PIXELS - sent;
      pause_at = (first || $urandom_range(0, 5) == 0) ? count / 2 : -1;
      first = 0;
      for (n = 0; n < count; n++) begin
        if (n == pause_at) wait_words_done();
        send_random_pixel();
      end
      sent += count;
    end
  endtask

  task automatic test_large_sizes();
    int n;
    // width above the maximum, row left unfinished
    configure(16'hFFFF, 1, 1, bavg_pkg::MODE_ALL);
    for (n = 0; n < 40; n++) send_random_pixel();
    // tallest image, left unfinished
    configure(3, 16'hFFFF, 16, 3);
    for (n = 0; n < 3 * 16; n++) send_random_pixel();
    configure(16, 16, 16, bavg_pkg::MODE_ALL);
    for (n = 0; n < 256; n++) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_pass_through();
    test_special_cases();
    test_random_frames();
    test_large_sizes();
    settle();
    $display("covered %0d pixels over %0d register settings, %0d averaged words compared",
             pixels_sent, settings_used, words_checked);
    $display("modes 0 to 3, edge and clamped blocks, zero and oversized registers");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
